### design/lcpa_pkg.sv
// ----------------------------------------------------------------------------
// lcpa_pkg
// Shared types, constants and saturating helpers for the least-cost path
// assigner.
// ----------------------------------------------------------------------------
package lcpa_pkg;

  localparam int OpW     = 2;
  localparam int RouteW  = 4;
  localparam int LenW    = 16;
  localparam int CfgW    = 5;
  localparam int FinW    = 32;
  localparam int ItemW   = 24;

  localparam int DefMaxRoutes = 16;
  localparam int FifoDepth    = 2;

  localparam logic [FinW-1:0]  CostLimit = 32'h7FFF_FFFF;
  localparam logic [ItemW-1:0] ItemLimit = 24'hFF_FFFF;

  typedef enum logic [OpW-1:0] {
    OP_LOAD   = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // classified command handed from front to back
  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,  // write an in-range entry
    CMD_ASSIGN = 3'd1,  // scan and update
    CMD_READ   = 3'd2,  // report an in-range entry
    CMD_ECHO   = 3'd3,  // echo index, all else zero
    CMD_NONE   = 3'd4   // assign with no active route
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [RouteW-1:0] idx;
    logic [LenW-1:0]   len;
  } cmd_t;

  typedef struct packed {
    logic [FinW-1:0]  cost;
    logic [FinW-1:0]  fin;
    logic [ItemW-1:0] items;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [FinW-1:0] sat_inc_cost(input logic [FinW-1:0] v);
    return (v >= CostLimit) ? CostLimit : v + FinW'(1);
  endfunction

  function automatic logic [ItemW-1:0] sat_inc_items(input logic [ItemW-1:0] v);
    return (v >= ItemLimit) ? ItemLimit : v + ItemW'(1);
  endfunction

endpackage

### design/lcpa_front.sv
// ----------------------------------------------------------------------------
// lcpa_front
// Holds the active route register, accepts input items and classifies them
// into commands for the queue.
// ----------------------------------------------------------------------------
module lcpa_front #(
  parameter int MAX_ROUTES = lcpa_pkg::DefMaxRoutes,
  parameter int CntW       = $clog2(MAX_ROUTES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lcpa_pkg::CfgW-1:0]   cfg_active_routes_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lcpa_pkg::OpW-1:0]    op_i,
  input  logic [lcpa_pkg::RouteW-1:0] route_index_i,
  input  logic [lcpa_pkg::LenW-1:0]   route_length_i,
  input  lcpa_pkg::q_stat_t           q_stat_i,
  output logic                        push_o,
  output lcpa_pkg::cmd_t              cmd_o,
  output logic [CntW-1:0]             n_routes_o
);

  logic [lcpa_pkg::CfgW-1:0] active_q, active_d;
  logic                      in_range;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    active_d = active_q;
    if (cfg_valid_i) begin
      active_d = cfg_active_routes_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else begin
      active_q <= active_d;
    end
  end

  // counts above the table size select over the whole table
  always_comb begin
    if (32'(active_q) > MAX_ROUTES) begin
      n_routes_o = CntW'(MAX_ROUTES);
    end else begin
      n_routes_o = CntW'(active_q);
    end
  end

  assign in_range   = 32'(route_index_i) < MAX_ROUTES;
  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    cmd_o.idx  = route_index_i;
    cmd_o.len  = route_length_i;
    cmd_o.kind = lcpa_pkg::CMD_ECHO;
    unique case (lcpa_pkg::op_e'(op_i))
      lcpa_pkg::OP_LOAD: begin
        cmd_o.kind = in_range ? lcpa_pkg::CMD_LOAD : lcpa_pkg::CMD_ECHO;
      end
      lcpa_pkg::OP_ASSIGN: begin
        cmd_o.kind = (n_routes_o == '0) ? lcpa_pkg::CMD_NONE : lcpa_pkg::CMD_ASSIGN;
      end
      lcpa_pkg::OP_READ: begin
        cmd_o.kind = in_range ? lcpa_pkg::CMD_READ : lcpa_pkg::CMD_ECHO;
      end
      lcpa_pkg::OP_NOP: begin
        cmd_o.kind = lcpa_pkg::CMD_ECHO;
      end
    endcase
  end

endmodule

### design/lcpa_fifo.sv
// ----------------------------------------------------------------------------
// lcpa_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module lcpa_fifo #(
  parameter int DEPTH = lcpa_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lcpa_pkg::cmd_t    data_i,
  input  logic              pop_i,
  output lcpa_pkg::cmd_t    data_o,
  output lcpa_pkg::q_stat_t stat_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  lcpa_pkg::cmd_t  store_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(DEPTH));
  assign data_o       = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/lcpa_back.sv
// ----------------------------------------------------------------------------
// lcpa_back
// Route table memory, sequential minimum scan with one comparator, entry
// update and the output register.
// ----------------------------------------------------------------------------
module lcpa_back #(
  parameter int MAX_ROUTES = lcpa_pkg::DefMaxRoutes,
  parameter int CntW       = $clog2(MAX_ROUTES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [CntW-1:0]             n_routes_i,
  input  lcpa_pkg::q_stat_t           q_stat_i,
  input  lcpa_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lcpa_pkg::RouteW-1:0] chosen_route_o,
  output logic [lcpa_pkg::FinW-1:0]   finish_turn_o,
  output logic [lcpa_pkg::ItemW-1:0]  items_on_route_o,
  output logic                        no_route_o
);

  localparam int IdxW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_UPDATE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  lcpa_pkg::entry_t mem [MAX_ROUTES];
  lcpa_pkg::entry_t rd_q;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic             we;
  logic [IdxW-1:0]  wa;
  lcpa_pkg::entry_t wd;

  logic [IdxW-1:0]             cnt_q, cnt_d;
  lcpa_pkg::entry_t            best_q, best_d;
  logic [IdxW-1:0]             best_idx_q, best_idx_d;
  logic [lcpa_pkg::RouteW-1:0] rdidx_q, rdidx_d;
  lcpa_pkg::entry_t            upd;

  logic                        slot_free;
  logic                        out_load;
  logic                        out_valid_q, out_valid_d;
  logic [lcpa_pkg::RouteW-1:0] res_route_q, res_route_d;
  logic [lcpa_pkg::FinW-1:0]   res_fin_q, res_fin_d;
  logic [lcpa_pkg::ItemW-1:0]  res_items_q, res_items_d;
  logic                        res_none_q, res_none_d;
  logic                        scan_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign scan_last = (CntW'(cnt_q) + CntW'(1)) == n_routes_i;

  // first assignment starts the finish turn at the current cost
  always_comb begin
    upd.cost  = lcpa_pkg::sat_inc_cost(best_q.cost);
    upd.items = lcpa_pkg::sat_inc_items(best_q.items);
    if (best_q.fin == '0) begin
      upd.fin = (best_q.cost > lcpa_pkg::CostLimit) ? lcpa_pkg::CostLimit : best_q.cost;
    end else begin
      upd.fin = lcpa_pkg::sat_inc_cost(best_q.fin);
    end
  end

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    we          = 1'b0;
    wa          = '0;
    wd          = '0;
    out_load    = 1'b0;
    res_route_d = '0;
    res_fin_d   = '0;
    res_items_d = '0;
    res_none_d  = 1'b0;
    cnt_d       = cnt_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    rdidx_d     = rdidx_q;
    unique case (state_q)
      S_IDLE: begin
        if (!q_stat_i.empty) begin
          unique case (cmd_i.kind)
            lcpa_pkg::CMD_LOAD: begin
              if (slot_free) begin
                pop_o       = 1'b1;
                we          = 1'b1;
                wa          = IdxW'(cmd_i.idx);
                wd.cost     = lcpa_pkg::FinW'(cmd_i.len);
                wd.fin      = '0;
                wd.items    = '0;
                out_load    = 1'b1;
                res_route_d = cmd_i.idx;
              end
            end
            lcpa_pkg::CMD_READ: begin
              pop_o   = 1'b1;
              rd_en   = 1'b1;
              rd_addr = IdxW'(cmd_i.idx);
              rdidx_d = cmd_i.idx;
              state_d = S_READ;
            end
            lcpa_pkg::CMD_ASSIGN: begin
              pop_o   = 1'b1;
              rd_en   = 1'b1;
              rd_addr = '0;
              cnt_d   = '0;
              state_d = S_SCAN;
            end
            lcpa_pkg::CMD_NONE: begin
              if (slot_free) begin
                pop_o      = 1'b1;
                out_load   = 1'b1;
                res_none_d = 1'b1;
              end
            end
            default: begin
              if (slot_free) begin
                pop_o       = 1'b1;
                out_load    = 1'b1;
                res_route_d = cmd_i.idx;
              end
            end
          endcase
        end
      end
      S_READ: begin
        if (slot_free) begin
          out_load    = 1'b1;
          res_route_d = rdidx_q;
          res_fin_d   = rd_q.fin;
          res_items_d = rd_q.items;
          state_d     = S_IDLE;
        end
      end
      S_SCAN: begin
        // strict less keeps the lowest index on a tie
        if ((cnt_q == '0) || (rd_q.cost < best_q.cost)) begin
          best_d     = rd_q;
          best_idx_d = cnt_q;
        end
        if (scan_last) begin
          state_d = S_UPDATE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cnt_q + IdxW'(1);
          cnt_d   = cnt_q + IdxW'(1);
        end
      end
      S_UPDATE: begin
        if (slot_free) begin
          we          = 1'b1;
          wa          = best_idx_q;
          wd          = upd;
          out_load    = 1'b1;
          res_route_d = lcpa_pkg::RouteW'(best_idx_q);
          res_fin_d   = upd.fin;
          res_items_d = upd.items;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    rdidx_q    <= rdidx_d;
    if (out_load) begin
      res_route_q <= res_route_d;
      res_fin_q   <= res_fin_d;
      res_items_q <= res_items_d;
      res_none_q  <= res_none_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign chosen_route_o   = res_route_q;
  assign finish_turn_o    = res_fin_q;
  assign items_on_route_o = res_items_q;
  assign no_route_o       = res_none_q;

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CntW'(cnt_q) < n_routes_i))
    else $error("scan index beyond active routes");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> ((state_q == S_IDLE) || (state_q == S_UPDATE)))
    else $error("table write outside load or update");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> ((state_q == S_IDLE) && !q_stat_i.empty))
    else $error("queue pop while busy or empty");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> slot_free)
    else $error("result overwrites an untaken result");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_none_d) |-> ((res_route_d == '0) && (res_fin_d == '0)
                                  && (res_items_d == '0)))
    else $error("no-route result carries data");

endmodule

### design/least_cost_path_assigner.sv
// ----------------------------------------------------------------------------
// least_cost_path_assigner
// Route table with greedy least-cost assignment: front classifies items, a
// two-entry queue decouples it from the back that owns the table.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_active_routes_i | in
//  in      | in_valid_i/in_ready_o, op_i, route_index_i,   | in
//          | route_length_i                             |
//  out     | out_valid_o/out_ready_i, chosen_route_o,    | out
//          | finish_turn_o, items_on_route_o, no_route_o |
//
//  Load, echo and no-route items complete from the idle state; read goes on to the
//  read state. Assign scans the active entries and then updates the chosen one:
//  one table entry per cycle through the single memory read port and one comparator.
//  Reset clears control state only; table entries are undefined until loaded.
//  A two-deep command queue and the output register let input transfers
//  continue while a result waits on out_ready_i.
// ----------------------------------------------------------------------------
module least_cost_path_assigner #(
  parameter int MAX_ROUTES = lcpa_pkg::DefMaxRoutes
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lcpa_pkg::CfgW-1:0]   cfg_active_routes_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lcpa_pkg::OpW-1:0]    op_i,
  input  logic [lcpa_pkg::RouteW-1:0] route_index_i,
  input  logic [lcpa_pkg::LenW-1:0]   route_length_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lcpa_pkg::RouteW-1:0] chosen_route_o,
  output logic [lcpa_pkg::FinW-1:0]   finish_turn_o,
  output logic [lcpa_pkg::ItemW-1:0]  items_on_route_o,
  output logic                        no_route_o
);

  localparam int CntW = $clog2(MAX_ROUTES + 1);

  lcpa_pkg::q_stat_t q_stat;
  lcpa_pkg::cmd_t    push_cmd;
  lcpa_pkg::cmd_t    head_cmd;
  logic              push;
  logic              pop;
  logic [CntW-1:0]   n_routes;

  lcpa_front #(
    .MAX_ROUTES (MAX_ROUTES),
    .CntW       (CntW)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_active_routes_i (cfg_active_routes_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .op_i                (op_i),
    .route_index_i       (route_index_i),
    .route_length_i      (route_length_i),
    .q_stat_i            (q_stat),
    .push_o              (push),
    .cmd_o               (push_cmd),
    .n_routes_o          (n_routes)
  );

  lcpa_fifo #(
    .DEPTH (lcpa_pkg::FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .pop_i  (pop),
    .data_o (head_cmd),
    .stat_o (q_stat)
  );

  lcpa_back #(
    .MAX_ROUTES (MAX_ROUTES),
    .CntW       (CntW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .n_routes_i       (n_routes),
    .q_stat_i         (q_stat),
    .cmd_i            (head_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .chosen_route_o   (chosen_route_o),
    .finish_turn_o    (finish_turn_o),
    .items_on_route_o (items_on_route_o),
    .no_route_o       (no_route_o)
  );

endmodule
